### hw/rtl/ostseq_pkg.sv
// shared types and codes for the obstacle scan and turn sequencer
// no dependencies; used by every module of the block by scoped names
package ostseq_pkg;

  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned CfgDataW = 32;

  // register indexes on the configuration port
  localparam logic [2:0] REG_OBSTACLE_MM    = 3'd0;
  localparam logic [2:0] REG_DIRECT_TURN_MM = 3'd1;
  localparam logic [2:0] REG_CRUISE_SPEED   = 3'd2;
  localparam logic [2:0] REG_SPIN_SPEED     = 3'd3;
  localparam logic [2:0] REG_SWEEP_MS       = 3'd4;
  localparam logic [2:0] REG_SETTLE_MS      = 3'd5;
  localparam logic [2:0] REG_STOP_MS        = 3'd6;
  localparam logic [2:0] REG_TURN_TIMEOUT   = 3'd7;

  // motor commands
  localparam logic [2:0] MOTOR_KEEP  = 3'd0;
  localparam logic [2:0] MOTOR_STOP  = 3'd1;
  localparam logic [2:0] MOTOR_FWD   = 3'd2;
  localparam logic [2:0] MOTOR_LEFT  = 3'd3;
  localparam logic [2:0] MOTOR_RIGHT = 3'd4;

  // servo commands
  localparam logic [1:0] SERVO_KEEP  = 2'd0;
  localparam logic [1:0] SERVO_STOP  = 2'd1;
  localparam logic [1:0] SERVO_LEFT  = 2'd2;
  localparam logic [1:0] SERVO_RIGHT = 2'd3;

  // turn plan for the next encounter
  localparam logic [1:0] PLAN_SCAN  = 2'd0;
  localparam logic [1:0] PLAN_LEFT  = 2'd1;
  localparam logic [1:0] PLAN_RIGHT = 2'd2;

  localparam logic signed [15:0] YAW_TARGET  = 16'sd900;
  localparam logic [12:0]        SIDE_MARGIN = 13'd100;

  typedef enum logic [3:0] {
    PH_DRIVE        = 4'd0,
    PH_STOP_WAIT    = 4'd1,
    PH_SWEEP_LEFT   = 4'd2,
    PH_LEFT_SETTLE  = 4'd3,
    PH_SWEEP_RIGHT  = 4'd4,
    PH_RIGHT_SETTLE = 4'd5,
    PH_CENTER       = 4'd6,
    PH_CHOOSE       = 4'd7,
    PH_SCAN_LEFT    = 4'd8,
    PH_SCAN_RIGHT   = 4'd9,
    PH_DIRECT_LEFT  = 4'd10,
    PH_DIRECT_RIGHT = 4'd11
  } phase_t;

  typedef struct packed {
    logic [11:0] obstacle_mm;
    logic [11:0] direct_turn_mm;
    logic [14:0] cruise_speed;
    logic [14:0] spin_speed;
    logic [15:0] sweep_ms;
    logic [15:0] settle_ms;
    logic [15:0] stop_ms;
    logic [15:0] turn_timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic [11:0]        distance_mm;
    logic               distance_ok;
    logic signed [15:0] yaw_tenths;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] phase_start_ms;
    logic [11:0] left_range_mm;
    logic [11:0] right_range_mm;
    logic [1:0]  turn_plan;
  } seq_state_t;

  typedef struct packed {
    logic [2:0]  motor_cmd;
    logic [14:0] motor_speed;
    logic [1:0]  servo_cmd;
    logic        yaw_zero;
    logic        sensor_fault;
    logic [3:0]  state_code;
  } result_t;

endpackage

### hw/rtl/ostseq_cfg.sv
// configuration register file behind the apb-style port
// depends on ostseq_pkg for the register indexes and cfg_t
module ostseq_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ostseq_pkg::CfgAddrW-1:0]  paddr,
  input  logic [ostseq_pkg::CfgDataW-1:0]  pwdata,
  output logic [ostseq_pkg::CfgDataW-1:0]  prdata,
  output logic                             pready,
  output ostseq_pkg::cfg_t                 cfg
);

  ostseq_pkg::cfg_t cfg_r;
  logic [2:0]       idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.obstacle_mm     <= 12'd425;
      cfg_r.direct_turn_mm  <= 12'd300;
      cfg_r.cruise_speed    <= 15'd1800;
      cfg_r.spin_speed      <= 15'd2200;
      cfg_r.sweep_ms        <= 16'd300;
      cfg_r.settle_ms       <= 16'd300;
      cfg_r.stop_ms         <= 16'd1000;
      cfg_r.turn_timeout_ms <= 16'd3500;
    end else if (wr_en) begin
      unique case (idx)
        ostseq_pkg::REG_OBSTACLE_MM:    cfg_r.obstacle_mm     <= pwdata[11:0];
        ostseq_pkg::REG_DIRECT_TURN_MM: cfg_r.direct_turn_mm  <= pwdata[11:0];
        ostseq_pkg::REG_CRUISE_SPEED:   cfg_r.cruise_speed    <= pwdata[14:0];
        ostseq_pkg::REG_SPIN_SPEED:     cfg_r.spin_speed      <= pwdata[14:0];
        ostseq_pkg::REG_SWEEP_MS:       cfg_r.sweep_ms        <= pwdata[15:0];
        ostseq_pkg::REG_SETTLE_MS:      cfg_r.settle_ms       <= pwdata[15:0];
        ostseq_pkg::REG_STOP_MS:        cfg_r.stop_ms         <= pwdata[15:0];
        ostseq_pkg::REG_TURN_TIMEOUT:   cfg_r.turn_timeout_ms <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ostseq_pkg::REG_OBSTACLE_MM:    prdata = {20'd0, cfg_r.obstacle_mm};
      ostseq_pkg::REG_DIRECT_TURN_MM: prdata = {20'd0, cfg_r.direct_turn_mm};
      ostseq_pkg::REG_CRUISE_SPEED:   prdata = {17'd0, cfg_r.cruise_speed};
      ostseq_pkg::REG_SPIN_SPEED:     prdata = {17'd0, cfg_r.spin_speed};
      ostseq_pkg::REG_SWEEP_MS:       prdata = {16'd0, cfg_r.sweep_ms};
      ostseq_pkg::REG_SETTLE_MS:      prdata = {16'd0, cfg_r.settle_ms};
      ostseq_pkg::REG_STOP_MS:        prdata = {16'd0, cfg_r.stop_ms};
      ostseq_pkg::REG_TURN_TIMEOUT:   prdata = {16'd0, cfg_r.turn_timeout_ms};
      default:                        prdata = '0;
    endcase
  end

endmodule

### hw/rtl/ostseq_step.sv
// next-state and result logic for one poll item
// depends on ostseq_pkg for the phase codes, commands and structs
module ostseq_step (
  input  ostseq_pkg::cfg_t       cfg,
  input  ostseq_pkg::item_t      item,
  input  ostseq_pkg::seq_state_t st,
  output ostseq_pkg::seq_state_t st_nxt,
  output ostseq_pkg::result_t    res
);

  logic [31:0] elapsed;
  logic [11:0] thresh;
  logic        sweep_done;
  logic        sweep2_done;
  logic        settle_done;
  logic        stop_done;
  logic        timeout;
  logic        left_done;
  logic        right_done;
  logic        go_left;
  logic [2:0]  motor;
  logic [14:0] speed;
  logic [1:0]  servo;
  logic        zero;
  logic        fault;

  assign elapsed     = item.now_ms - st.phase_start_ms;
  assign thresh      = (st.turn_plan == ostseq_pkg::PLAN_SCAN) ? cfg.obstacle_mm
                                                               : cfg.direct_turn_mm;
  assign sweep_done  = elapsed >= {16'd0, cfg.sweep_ms};
  assign sweep2_done = elapsed >= {15'd0, cfg.sweep_ms, 1'b0};
  assign settle_done = elapsed >= {16'd0, cfg.settle_ms};
  assign stop_done   = elapsed >= {16'd0, cfg.stop_ms};
  assign timeout     = elapsed >= {16'd0, cfg.turn_timeout_ms};
  assign left_done   = (item.yaw_tenths <= -ostseq_pkg::YAW_TARGET) || timeout;
  assign right_done  = (item.yaw_tenths >= ostseq_pkg::YAW_TARGET) || timeout;
  assign go_left     = {1'b0, st.left_range_mm} >
                       ({1'b0, st.right_range_mm} + ostseq_pkg::SIDE_MARGIN);

  always_comb begin
    st_nxt = st;
    motor  = ostseq_pkg::MOTOR_KEEP;
    speed  = '0;
    servo  = ostseq_pkg::SERVO_KEEP;
    zero   = 1'b0;
    fault  = 1'b0;
    unique case (st.phase)
      ostseq_pkg::PH_DRIVE: begin
        if (!item.distance_ok) begin
          motor = ostseq_pkg::MOTOR_STOP;
          fault = 1'b1;
        end else if (item.distance_mm <= thresh) begin
          st_nxt.phase_start_ms = item.now_ms;
          if (st.turn_plan == ostseq_pkg::PLAN_LEFT) begin
            motor        = ostseq_pkg::MOTOR_LEFT;
            speed        = cfg.spin_speed;
            zero         = 1'b1;
            st_nxt.phase = ostseq_pkg::PH_DIRECT_LEFT;
          end else if (st.turn_plan == ostseq_pkg::PLAN_RIGHT) begin
            motor        = ostseq_pkg::MOTOR_RIGHT;
            speed        = cfg.spin_speed;
            zero         = 1'b1;
            st_nxt.phase = ostseq_pkg::PH_DIRECT_RIGHT;
          end else begin
            motor        = ostseq_pkg::MOTOR_STOP;
            st_nxt.phase = ostseq_pkg::PH_STOP_WAIT;
          end
        end else begin
          motor = ostseq_pkg::MOTOR_FWD;
          speed = cfg.cruise_speed;
        end
      end
      ostseq_pkg::PH_STOP_WAIT: begin
        if (stop_done) begin
          st_nxt.left_range_mm  = '0;
          st_nxt.right_range_mm = '0;
          motor                 = ostseq_pkg::MOTOR_STOP;
          servo                 = ostseq_pkg::SERVO_LEFT;
          st_nxt.phase          = ostseq_pkg::PH_SWEEP_LEFT;
          st_nxt.phase_start_ms = item.now_ms;
        end
      end
      ostseq_pkg::PH_SWEEP_LEFT: begin
        if (sweep_done) begin
          servo                 = ostseq_pkg::SERVO_STOP;
          st_nxt.phase          = ostseq_pkg::PH_LEFT_SETTLE;
          st_nxt.phase_start_ms = item.now_ms;
        end
      end
      ostseq_pkg::PH_LEFT_SETTLE: begin
        if (settle_done) begin
          st_nxt.phase_start_ms = item.now_ms;
          // bad reading restarts the settle wait
          if (!item.distance_ok) begin
            motor = ostseq_pkg::MOTOR_STOP;
            fault = 1'b1;
          end else begin
            st_nxt.left_range_mm = item.distance_mm;
            servo                = ostseq_pkg::SERVO_RIGHT;
            st_nxt.phase         = ostseq_pkg::PH_SWEEP_RIGHT;
          end
        end
      end
      ostseq_pkg::PH_SWEEP_RIGHT: begin
        // full swing from left to right takes two side sweeps
        if (sweep2_done) begin
          servo                 = ostseq_pkg::SERVO_STOP;
          st_nxt.phase          = ostseq_pkg::PH_RIGHT_SETTLE;
          st_nxt.phase_start_ms = item.now_ms;
        end
      end
      ostseq_pkg::PH_RIGHT_SETTLE: begin
        if (settle_done) begin
          st_nxt.phase_start_ms = item.now_ms;
          if (!item.distance_ok) begin
            motor = ostseq_pkg::MOTOR_STOP;
            fault = 1'b1;
          end else begin
            st_nxt.right_range_mm = item.distance_mm;
            servo                 = ostseq_pkg::SERVO_LEFT;
            st_nxt.phase          = ostseq_pkg::PH_CENTER;
          end
        end
      end
      ostseq_pkg::PH_CENTER: begin
        if (sweep_done) begin
          servo                 = ostseq_pkg::SERVO_STOP;
          st_nxt.phase          = ostseq_pkg::PH_CHOOSE;
          st_nxt.phase_start_ms = item.now_ms;
        end
      end
      ostseq_pkg::PH_CHOOSE: begin
        zero                  = 1'b1;
        speed                 = cfg.spin_speed;
        st_nxt.phase_start_ms = item.now_ms;
        if (go_left) begin
          motor        = ostseq_pkg::MOTOR_LEFT;
          st_nxt.phase = ostseq_pkg::PH_SCAN_LEFT;
        end else begin
          motor        = ostseq_pkg::MOTOR_RIGHT;
          st_nxt.phase = ostseq_pkg::PH_SCAN_RIGHT;
        end
      end
      ostseq_pkg::PH_SCAN_LEFT, ostseq_pkg::PH_SCAN_RIGHT,
      ostseq_pkg::PH_DIRECT_LEFT, ostseq_pkg::PH_DIRECT_RIGHT: begin
        // after a scan turn the next encounter turns the other way
        if ((st.phase == ostseq_pkg::PH_SCAN_LEFT && left_done) ||
            (st.phase == ostseq_pkg::PH_DIRECT_LEFT && left_done) ||
            (st.phase == ostseq_pkg::PH_SCAN_RIGHT && right_done) ||
            (st.phase == ostseq_pkg::PH_DIRECT_RIGHT && right_done)) begin
          motor                 = ostseq_pkg::MOTOR_STOP;
          st_nxt.phase          = ostseq_pkg::PH_DRIVE;
          st_nxt.phase_start_ms = item.now_ms;
          if (st.phase == ostseq_pkg::PH_SCAN_LEFT) begin
            st_nxt.turn_plan = ostseq_pkg::PLAN_RIGHT;
          end else if (st.phase == ostseq_pkg::PH_SCAN_RIGHT) begin
            st_nxt.turn_plan = ostseq_pkg::PLAN_LEFT;
          end else begin
            st_nxt.turn_plan = ostseq_pkg::PLAN_SCAN;
          end
        end
      end
      default: begin
        motor                 = ostseq_pkg::MOTOR_STOP;
        st_nxt.phase          = ostseq_pkg::PH_DRIVE;
        st_nxt.phase_start_ms = item.now_ms;
        st_nxt.left_range_mm  = '0;
        st_nxt.right_range_mm = '0;
        st_nxt.turn_plan      = ostseq_pkg::PLAN_SCAN;
      end
    endcase
  end

  always_comb begin
    res.motor_cmd    = motor;
    res.motor_speed  = speed;
    res.servo_cmd    = servo;
    res.yaw_zero     = zero;
    res.sensor_fault = fault;
    res.state_code   = st_nxt.phase;
  end

endmodule

### hw/rtl/obstacle_scan_turn_sequencer.sv
// Obstacle scan and turn sequencer, top level.
// Input channel (in_valid/in_ready) takes one poll transfer: timestamp, front
// range with valid flag and relative yaw. Result channel (out_valid/out_ready)
// gives exactly one result transfer per poll: motor and servo commands, yaw
// zero pulse, sensor fault flag and the phase after the step.
// The poll is captured in an input register; the phase logic runs between it
// and the result register, which takes the result when the poll moves on. One
// poll per cycle is sustained while out_ready is high: the sequencer state
// updates together with the result register, when a poll moves into it.
// When the receiver stalls, the result register holds its transfer and one
// more poll waits in the input register; in_ready drops only when both are
// full and out_ready is low.
// Configuration goes through the apb-style cfg_ port, one 32-bit register
// every 4 bytes, with no wait states; write it only while the block is idle.
// Synchronous active-low reset empties both registers, returns the sequencer
// to the drive phase with cleared ranges and plan, and loads register
// defaults.
// Depends on ostseq_pkg, ostseq_cfg and ostseq_step.
module obstacle_scan_turn_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [31:0]                      in_now_ms,
  input  logic [11:0]                      in_distance_mm,
  input  logic                             in_distance_ok,
  input  logic signed [15:0]               in_yaw_tenths,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0]                       out_motor_cmd,
  output logic [14:0]                      out_motor_speed,
  output logic [1:0]                       out_servo_cmd,
  output logic                             out_yaw_zero,
  output logic                             out_sensor_fault,
  output logic [3:0]                       out_state_code,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ostseq_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [ostseq_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [ostseq_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                             cfg_pready
);

  ostseq_pkg::cfg_t       cfg;
  ostseq_pkg::item_t      item_r;
  logic                   in_v_r;
  ostseq_pkg::result_t    res_r;
  ostseq_pkg::result_t    res_nxt;
  logic                   out_v_r;
  ostseq_pkg::seq_state_t st_r;
  ostseq_pkg::seq_state_t st_nxt;
  logic                   adv;

  ostseq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  ostseq_step u_step (
    .cfg    (cfg),
    .item   (item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // poll moves to the result register when that register is free or drains
  assign adv      = in_v_r & (~out_v_r | out_ready);
  assign in_ready = ~in_v_r | adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r            <= 1'b0;
      out_v_r           <= 1'b0;
      st_r.phase          <= ostseq_pkg::PH_DRIVE;
      st_r.phase_start_ms <= '0;
      st_r.left_range_mm  <= '0;
      st_r.right_range_mm <= '0;
      st_r.turn_plan      <= ostseq_pkg::PLAN_SCAN;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
        st_r    <= st_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.now_ms      <= in_now_ms;
      item_r.distance_mm <= in_distance_mm;
      item_r.distance_ok <= in_distance_ok;
      item_r.yaw_tenths  <= in_yaw_tenths;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_motor_cmd    = res_r.motor_cmd;
  assign out_motor_speed  = res_r.motor_speed;
  assign out_servo_cmd    = res_r.servo_cmd;
  assign out_yaw_zero     = res_r.yaw_zero;
  assign out_sensor_fault = res_r.sensor_fault;
  assign out_state_code   = res_r.state_code;

  // sequencer state changes only when a poll is consumed
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st_r))
    else $error("sequencer state changed without a poll");

  // an empty result register never blocks the input side
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ready)
    else $error("input stalled while result register empty");

  // yaw zero pulse only comes with a spin command
  a_zero_spin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && res_r.yaw_zero) |->
      (res_r.motor_cmd == ostseq_pkg::MOTOR_LEFT ||
       res_r.motor_cmd == ostseq_pkg::MOTOR_RIGHT))
    else $error("yaw zero without spin");

  // the reported phase is the one held in the sequencer after the step
  a_code_match: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> (res_r.state_code == st_r.phase))
    else $error("state code does not match sequencer phase");

endmodule

### bench/obstacle_scan_turn_sequencer_test.sv
// testbench for obstacle_scan_turn_sequencer: directed then random polls,
// with a scoreboard class that predicts every result and checks it field by field
// depends on ostseq_pkg and the obstacle_scan_turn_sequencer rtl
`timescale 1ns / 1ps

module obstacle_scan_turn_sequencer_test;
  import ostseq_pkg::*;

  class scan_turn_scoreboard;
    cfg_t        regs;
    phase_t      phase;
    logic [31:0] phase_ms;
    logic [11:0] left_mm;
    logic [11:0] right_mm;
    logic [1:0]  plan;
    result_t     res;
    result_t     predicted_cmds[$];
    int          errors;

    function new();
      regs.obstacle_mm     = 12'd425;
      regs.direct_turn_mm  = 12'd300;
      regs.cruise_speed    = 15'd1800;
      regs.spin_speed      = 15'd2200;
      regs.sweep_ms        = 16'd300;
      regs.settle_ms       = 16'd300;
      regs.stop_ms         = 16'd1000;
      regs.turn_timeout_ms = 16'd3500;
      phase    = PH_DRIVE;
      phase_ms = '0;
      left_mm  = '0;
      right_mm = '0;
      plan     = PLAN_SCAN;
      errors   = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_OBSTACLE_MM:    regs.obstacle_mm = v[11:0];
        REG_DIRECT_TURN_MM: regs.direct_turn_mm = v[11:0];
        REG_CRUISE_SPEED:   regs.cruise_speed = v[14:0];
        REG_SPIN_SPEED:     regs.spin_speed = v[14:0];
        REG_SWEEP_MS:       regs.sweep_ms = v[15:0];
        REG_SETTLE_MS:      regs.settle_ms = v[15:0];
        REG_STOP_MS:        regs.stop_ms = v[15:0];
        REG_TURN_TIMEOUT:   regs.turn_timeout_ms = v[15:0];
        default: ;
      endcase
    endfunction

    function void start_spin(bit left, phase_t next, logic [31:0] now);
      res.yaw_zero    = 1'b1;
      res.motor_cmd   = left ? MOTOR_LEFT : MOTOR_RIGHT;
      res.motor_speed = regs.spin_speed;
      phase    = next;
      phase_ms = now;
    endfunction

    // a spin ends on reaching the yaw target or on the timeout
    function void end_spin_on(bit left, logic signed [15:0] yaw, logic [31:0] now,
                              logic [1:0] plan_after);
      bit done;
      done = left ? (yaw <= -YAW_TARGET) : (yaw >= YAW_TARGET);
      if (done || (now - phase_ms) >= {16'd0, regs.turn_timeout_ms}) begin
        res.motor_cmd = MOTOR_STOP;
        plan     = plan_after;
        phase    = PH_DRIVE;
        phase_ms = now;
      end
    endfunction

    function void note_poll(item_t it);
      logic [31:0]        elapsed;
      logic [11:0]        limit;
      logic signed [15:0] yaw;
      elapsed = it.now_ms - phase_ms;
      yaw     = it.yaw_tenths;
      res     = '0;
      res.motor_cmd = MOTOR_KEEP;
      res.servo_cmd = SERVO_KEEP;
      case (phase)
        PH_DRIVE: begin
          limit = (plan == PLAN_SCAN) ? regs.obstacle_mm : regs.direct_turn_mm;
          if (!it.distance_ok) begin
            res.motor_cmd    = MOTOR_STOP;
            res.sensor_fault = 1'b1;
          end else if (it.distance_mm <= limit) begin
            res.motor_cmd = MOTOR_STOP;
            phase_ms      = it.now_ms;
            if (plan == PLAN_LEFT) start_spin(1'b1, PH_DIRECT_LEFT, it.now_ms);
            else if (plan == PLAN_RIGHT) start_spin(1'b0, PH_DIRECT_RIGHT, it.now_ms);
            else phase = PH_STOP_WAIT;
          end else begin
            res.motor_cmd   = MOTOR_FWD;
            res.motor_speed = regs.cruise_speed;
          end
        end
        PH_STOP_WAIT: begin
          if (elapsed >= {16'd0, regs.stop_ms}) begin
            left_mm       = '0;
            right_mm      = '0;
            res.motor_cmd = MOTOR_STOP;
            res.servo_cmd = SERVO_LEFT;
            phase         = PH_SWEEP_LEFT;
            phase_ms      = it.now_ms;
          end
        end
        PH_SWEEP_LEFT: begin
          if (elapsed >= {16'd0, regs.sweep_ms}) begin
            res.servo_cmd = SERVO_STOP;
            phase         = PH_LEFT_SETTLE;
            phase_ms      = it.now_ms;
          end
        end
        PH_LEFT_SETTLE: begin
          if (elapsed >= {16'd0, regs.settle_ms}) begin
            phase_ms = it.now_ms;
            // a bad reading keeps the old range and restarts the settle wait
            if (!it.distance_ok) begin
              res.motor_cmd    = MOTOR_STOP;
              res.sensor_fault = 1'b1;
            end else begin
              left_mm       = it.distance_mm;
              res.servo_cmd = SERVO_RIGHT;
              phase         = PH_SWEEP_RIGHT;
            end
          end
        end
        PH_SWEEP_RIGHT: begin
          // the servo swings across the center, so twice the sweep time
          if (elapsed >= {15'd0, regs.sweep_ms, 1'b0}) begin
            res.servo_cmd = SERVO_STOP;
            phase         = PH_RIGHT_SETTLE;
            phase_ms      = it.now_ms;
          end
        end
        PH_RIGHT_SETTLE: begin
          if (elapsed >= {16'd0, regs.settle_ms}) begin
            phase_ms = it.now_ms;
            if (!it.distance_ok) begin
              res.motor_cmd    = MOTOR_STOP;
              res.sensor_fault = 1'b1;
            end else begin
              right_mm      = it.distance_mm;
              res.servo_cmd = SERVO_LEFT;
              phase         = PH_CENTER;
            end
          end
        end
        PH_CENTER: begin
          if (elapsed >= {16'd0, regs.sweep_ms}) begin
            res.servo_cmd = SERVO_STOP;
            phase         = PH_CHOOSE;
            phase_ms      = it.now_ms;
          end
        end
        PH_CHOOSE: begin
          if ({1'b0, left_mm} > {1'b0, right_mm} + SIDE_MARGIN)
            start_spin(1'b1, PH_SCAN_LEFT, it.now_ms);
          else
            start_spin(1'b0, PH_SCAN_RIGHT, it.now_ms);
        end
        PH_SCAN_LEFT:    end_spin_on(1'b1, yaw, it.now_ms, PLAN_RIGHT);
        PH_SCAN_RIGHT:   end_spin_on(1'b0, yaw, it.now_ms, PLAN_LEFT);
        PH_DIRECT_LEFT:  end_spin_on(1'b1, yaw, it.now_ms, PLAN_SCAN);
        PH_DIRECT_RIGHT: end_spin_on(1'b0, yaw, it.now_ms, PLAN_SCAN);
        default: begin
          res.motor_cmd = MOTOR_STOP;
          phase    = PH_DRIVE;
          phase_ms = it.now_ms;
          left_mm  = '0;
          right_mm = '0;
          plan     = PLAN_SCAN;
        end
      endcase
      res.state_code = phase;
      predicted_cmds.push_back(res);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (predicted_cmds.size() == 0) begin
        $error("result transfer with no poll outstanding");
        errors++;
      end else begin
        want = predicted_cmds.pop_front();
        check_field("motor_cmd", 32'(want.motor_cmd), 32'(got.motor_cmd));
        check_field("motor_speed", 32'(want.motor_speed), 32'(got.motor_speed));
        check_field("servo_cmd", 32'(want.servo_cmd), 32'(got.servo_cmd));
        check_field("yaw_zero", 32'(want.yaw_zero), 32'(got.yaw_zero));
        check_field("sensor_fault", 32'(want.sensor_fault), 32'(got.sensor_fault));
        check_field("state_code", 32'(want.state_code), 32'(got.state_code));
      end
    endfunction

    function int pending();
      return predicted_cmds.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid;
  logic                in_ready;
  logic [31:0]         in_now_ms;
  logic [11:0]         in_distance_mm;
  logic                in_distance_ok;
  logic signed [15:0]  in_yaw_tenths;
  logic                out_valid;
  logic                out_ready;
  logic [2:0]          out_motor_cmd;
  logic [14:0]         out_motor_speed;
  logic [1:0]          out_servo_cmd;
  logic                out_yaw_zero;
  logic                out_sensor_fault;
  logic [3:0]          out_state_code;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CfgAddrW-1:0] cfg_paddr;
  logic [CfgDataW-1:0] cfg_pwdata;
  logic [CfgDataW-1:0] cfg_prdata;
  logic                cfg_pready;

  scan_turn_scoreboard sb;
  logic [31:0]         clock_ms;
  int unsigned         step_max;
  bit                  calm;
  bit                  hold_req;

  obstacle_scan_turn_sequencer uut (.*);

  always #5 clk = ~clk;

  task automatic send_poll(input item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_now_ms      <= it.now_ms;
    in_distance_mm <= it.distance_mm;
    in_distance_ok <= it.distance_ok;
    in_yaw_tenths  <= it.yaw_tenths;
    do @(posedge clk); while (!in_ready);
    sb.note_poll(it);
  endtask

  task automatic poll(input logic [31:0] now, input logic [11:0] range_mm, input bit ok,
                      input logic signed [15:0] yaw);
    item_t it;
    it.now_ms      = now;
    it.distance_mm = range_mm;
    it.distance_ok = ok;
    it.yaw_tenths  = yaw;
    send_poll(it);
  endtask

  // drop valid and let every outstanding result come back
  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk) cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic program_reg(input logic [2:0] idx, input logic [31:0] value);
    logic [31:0] back;
    cfg_access(1'b1, idx, value, back);
    cfg_access(1'b0, idx, '0, back);
    if (back !== value) begin
      $error("register %0d readback mismatch: expected %0d, actual %0d", idx, value, back);
      sb.errors++;
    end
    sb.write_reg(idx, value);
  endtask

  task automatic apply_config(input cfg_t c);
    program_reg(REG_OBSTACLE_MM, 32'(c.obstacle_mm));
    program_reg(REG_DIRECT_TURN_MM, 32'(c.direct_turn_mm));
    program_reg(REG_CRUISE_SPEED, 32'(c.cruise_speed));
    program_reg(REG_SPIN_SPEED, 32'(c.spin_speed));
    program_reg(REG_SWEEP_MS, 32'(c.sweep_ms));
    program_reg(REG_SETTLE_MS, 32'(c.settle_ms));
    program_reg(REG_STOP_MS, 32'(c.stop_ms));
    program_reg(REG_TURN_TIMEOUT, 32'(c.turn_timeout_ms));
  endtask

  // mostly time moving forward in steps that let the phases run through,
  // ranges clustered around the active threshold, yaw around the spin target
  function automatic item_t make_poll();
    item_t it;
    int    thr;
    int    d;
    int    y;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) clock_ms = $urandom;
    else clock_ms = clock_ms + $urandom_range(0, step_max);
    it.now_ms = clock_ms;
    thr  = (sb.plan == PLAN_SCAN) ? int'(sb.regs.obstacle_mm) : int'(sb.regs.direct_turn_mm);
    pick = $urandom_range(0, 99);
    if (pick < 15) d = thr + int'($urandom_range(0, 4)) - 2;
    else if (pick < 25) d = $urandom_range(0, thr);
    else d = $urandom_range(0, 4095);
    if (d < 0) d = 0;
    if (d > 4095) d = 4095;
    it.distance_mm = d[11:0];
    it.distance_ok = ($urandom_range(0, 99) >= 8);
    pick = $urandom_range(0, 99);
    if (pick < 35) y = $urandom;
    else if (pick < 70) y = int'($urandom_range(0, 1900)) - 950;
    else if (pick < 85) begin
      case ($urandom_range(0, 3))
        0: y = -900;
        1: y = -899;
        2: y = 899;
        default: y = 900;
      endcase
    end else y = int'($urandom_range(0, 200)) - 100;
    it.yaw_tenths = y[15:0];
    return it;
  endfunction

  initial begin : result_side
    int      stall;
    result_t got;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        // long hold-off so the block fills and stalls its input
        hold_req = 1'b0;
        stall    = 60;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.motor_cmd    = out_motor_cmd;
      got.motor_speed  = out_motor_speed;
      got.servo_cmd    = out_servo_cmd;
      got.yaw_zero     = out_yaw_zero;
      got.sensor_fault = out_sensor_fault;
      got.state_code   = out_state_code;
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    cfg_t         c;
    logic [127:0] raw;
    int unsigned  span;
    sb             = new();
    in_valid       = 1'b0;
    in_now_ms      = '0;
    in_distance_mm = '0;
    in_distance_ok = 1'b0;
    in_yaw_tenths  = '0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    clock_ms       = '0;
    step_max       = 1;
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // one full scan with reset registers: fault while driving, exact timer
    // edges, a bad side reading, left clearly clearer, yaw end of a left spin
    poll(32'd10, 12'd0, 1'b0, 16'sd0);
    poll(32'd20, 12'd4095, 1'b1, 16'sd32767);
    poll(32'd30, 12'd426, 1'b1, -16'sd32768);
    poll(32'd1000, 12'd425, 1'b1, 16'sd0);
    poll(32'd2000, 12'd0, 1'b0, 16'sd0);
    poll(32'd2300, 12'd0, 1'b1, 16'sd0);
    poll(32'd2600, 12'd0, 1'b0, 16'sd0);
    poll(32'd2900, 12'd4095, 1'b1, 16'sd0);
    poll(32'd3500, 12'd0, 1'b1, 16'sd0);
    poll(32'd3800, 12'd0, 1'b1, 16'sd0);
    poll(32'd4100, 12'd0, 1'b1, 16'sd0);
    poll(32'd4100, 12'd0, 1'b1, 16'sd0);
    poll(32'd4200, 12'd0, 1'b1, -16'sd899);
    poll(32'd4300, 12'd0, 1'b1, -16'sd900);
    // planned right turn on the direct threshold, ends on yaw
    poll(32'd4400, 12'd301, 1'b1, 16'sd0);
    poll(32'd4500, 12'd300, 1'b1, 16'sd0);
    poll(32'd4600, 12'd0, 1'b1, 16'sd32767);
    // scan across the timestamp wrap, sides tied at the margin, spin ends on timeout
    poll(32'hFFFF_FE00, 12'd425, 1'b1, 16'sd0);
    poll(32'h0000_01E8, 12'd0, 1'b1, 16'sd0);
    poll(32'h0000_0314, 12'd0, 1'b1, 16'sd0);
    poll(32'h0000_0440, 12'd200, 1'b1, 16'sd0);
    poll(32'h0000_0698, 12'd0, 1'b1, 16'sd0);
    poll(32'h0000_07C4, 12'd100, 1'b1, 16'sd0);
    poll(32'h0000_08F0, 12'd0, 1'b1, 16'sd0);
    poll(32'h0000_08F0, 12'd0, 1'b1, 16'sd0);
    poll(32'h0000_1693, 12'd0, 1'b1, 16'sd899);
    poll(32'h0000_1694, 12'd0, 1'b1, 16'sd899);
    poll(32'h0000_1700, 12'd300, 1'b1, 16'sd0);
    poll(32'h0000_24AC, 12'd0, 1'b1, 16'sd0);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      repeat (4) @(posedge clk);
      case (p)
        0, 5: begin
          raw = {$urandom, $urandom, $urandom, $urandom};
          c   = raw[$bits(cfg_t)-1:0];
          c.obstacle_mm     = 12'd200 + c.obstacle_mm % 12'd1300;
          c.direct_turn_mm  = 12'd50 + c.direct_turn_mm % 12'd1150;
          c.sweep_ms        = c.sweep_ms % 16'd400;
          c.settle_ms       = c.settle_ms % 16'd400;
          c.stop_ms         = c.stop_ms % 16'd1200;
          c.turn_timeout_ms = c.turn_timeout_ms % 16'd4000;
        end
        1: c = '0;
        2: c = '1;
        3: begin
          c.obstacle_mm     = 12'd425;
          c.direct_turn_mm  = 12'd300;
          c.cruise_speed    = 15'd1800;
          c.spin_speed      = 15'd2200;
          c.sweep_ms        = 16'd300;
          c.settle_ms       = 16'd300;
          c.stop_ms         = 16'd1000;
          c.turn_timeout_ms = 16'd3500;
        end
        default: begin
          raw = {$urandom, $urandom, $urandom, $urandom};
          c   = raw[$bits(cfg_t)-1:0];
        end
      endcase
      apply_config(c);
      span     = c.stop_ms + 2 * c.sweep_ms + c.settle_ms + c.turn_timeout_ms;
      step_max = span / 8 + 1;
      for (int i = 0; i < 115; i++) begin
        calm = (i >= 30 && i < 60);
        if (i == 70 && (p == 0 || p == 3)) hold_req = 1'b1;
        if (i == 90) wait_drained();
        send_poll(make_poll());
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
